>>> src/pia_pkg.sv
// ----------------------------------------------------------------------------
// pia_pkg: shared types and constants for the positional insert/erase array
// Operation and status codes, beat field layout and the per-cell command.
// ----------------------------------------------------------------------------
package pia_pkg;

    // field widths of the input and result beats
    localparam int OP_W     = 3;
    localparam int POS_W    = 5;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    // s_tdata layout
    localparam int OP_LSB    = 0;
    localparam int POS_LSB   = OP_LSB + OP_W;
    localparam int VALUE_LSB = POS_LSB + POS_W;
    localparam int S_DATA_W  = 40;

    // m_tdata layout
    localparam int RD_LSB     = 0;
    localparam int COUNT_LSB  = RD_LSB + VALUE_W;
    localparam int STATUS_LSB = COUNT_LSB + COUNT_W;
    localparam int M_DATA_W   = 40;
    localparam int M_PAD_W    = M_DATA_W - STATUS_LSB - STATUS_W;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 3'd0,
        OP_REMOVE = 3'd1,
        OP_INSERT = 3'd2,
        OP_ERASE  = 3'd3,
        OP_READ   = 3'd4,
        OP_CLEAR  = 3'd5
    } pia_op_e;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADIDX = 2'd3
    } pia_status_e;

    // command broadcast to every cell of the chain
    typedef struct packed {
        logic write;       // load the new word at the selected index
        logic shift_up;    // cells above the index take their lower neighbor
        logic shift_down;  // cells at or above the index take their upper neighbor
        logic read;        // selected cell drives its word onto the read bus
    } pia_cmd_t;

endpackage

>>> src/positional_insert_erase_array.sv
// ----------------------------------------------------------------------------
// positional_insert_erase_array: dense array with insert and erase by index
// Append, remove last, insert, erase, read and clear on up to DEPTH words,
// one result beat per operation with the word read, new count and status.
// ----------------------------------------------------------------------------
//  channel | dir | tdata fields (lsb first)               | beat
//  s_      | in  | op[2:0] position[4:0] value[31:0]      | one operation
//  m_      | out | read_value[31:0] count[4:0] status[1:0] | one result
//
//  one operation per cycle unless the output stalls; the result is registered on acceptance
//  every cell updates in the accepting cycle, so insert and erase shift the
//  whole chain at once; the read goes through an or-bus over the cells
//  reset clears the count and the output valid; cell words stay undefined
//  an output stall holds the result register and drops s_tready
// ----------------------------------------------------------------------------
module positional_insert_erase_array
    import pia_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int WORD_WIDTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // op[2:0], position[7:3], value[39:8]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // read_value[31:0], count[36:32],
                                           // status[38:37], zero pad[39]
);

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int KEEP_W = (WORD_WIDTH < VALUE_W) ? WORD_WIDTH : VALUE_W;

    logic                  accept;
    pia_op_e               op_in;
    logic [POS_W-1:0]      pos_in;
    logic [VALUE_W-1:0]    value_in;
    logic [CMP_W-1:0]      pos_ext;
    logic [CMP_W-1:0]      cnt_ext;
    logic                  is_full;
    logic                  is_empty;

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  m_valid_reg;
    logic                  m_valid_next;
    logic [M_DATA_W-1:0]   m_data_reg;
    logic [M_DATA_W-1:0]   m_data_next;

    pia_cmd_t              cmd;
    pia_cmd_t              cmd_gated;
    pia_status_e           status;
    logic [CMP_W-1:0]      sel_cmp;
    logic [IDX_W-1:0]      sel_idx;
    logic [WORD_WIDTH-1:0] wr_word;
    logic [WORD_WIDTH-1:0] cell_word [DEPTH];
    logic [WORD_WIDTH-1:0] cell_rd   [DEPTH];
    logic [WORD_WIDTH-1:0] rd_any;
    logic [VALUE_W-1:0]    read_value;

    // input beat fields
    assign op_in    = pia_op_e'(s_tdata[OP_LSB +: OP_W]);
    assign pos_in   = s_tdata[POS_LSB +: POS_W];
    assign value_in = s_tdata[VALUE_LSB +: VALUE_W];

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign pos_ext  = CMP_W'(pos_in);
    assign cnt_ext  = CMP_W'(count_reg);
    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);
    assign wr_word  = WORD_WIDTH'(value_in[KEEP_W-1:0]);

    // operation decode: status, new count and cell command
    always_comb begin
        cmd        = '0;
        status     = ST_OK;
        count_next = count_reg;
        sel_cmp    = pos_ext;
        unique case (op_in)
            OP_APPEND: begin
                if (is_full) begin
                    status = ST_FULL;
                end else begin
                    cmd.write  = 1'b1;
                    sel_cmp    = cnt_ext;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_REMOVE: begin
                if (is_empty) begin
                    status = ST_EMPTY;
                end else begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            OP_INSERT: begin
                if (is_full) begin
                    status = ST_FULL;
                end else if (pos_ext > cnt_ext) begin
                    status = ST_BADIDX;
                end else begin
                    cmd.write    = 1'b1;
                    cmd.shift_up = 1'b1;
                    count_next   = count_reg + CNT_W'(1);
                end
            end
            OP_ERASE: begin
                if (is_empty) begin
                    status = ST_EMPTY;
                end else if (pos_ext >= cnt_ext) begin
                    status = ST_BADIDX;
                end else begin
                    cmd.shift_down = 1'b1;
                    count_next     = count_reg - CNT_W'(1);
                end
            end
            OP_READ: begin
                if (pos_ext >= cnt_ext) begin
                    status = ST_BADIDX;
                end else begin
                    cmd.read = 1'b1;
                end
            end
            OP_CLEAR: begin
                count_next = '0;
            end
            default: begin
                count_next = count_reg;
            end
        endcase
    end

    assign sel_idx   = sel_cmp[IDX_W-1:0];
    assign cmd_gated = accept ? cmd : '0;

    // chain of cells, each linked to both neighbors
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [WORD_WIDTH-1:0] prev_w;
        logic [WORD_WIDTH-1:0] next_w;

        if (i == 0) begin : g_first
            assign prev_w = '0;
        end else begin : g_mid_lo
            assign prev_w = cell_word[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign next_w = cell_word[i];
        end else begin : g_mid_hi
            assign next_w = cell_word[i+1];
        end

        pia_cell #(
            .WORD_WIDTH (WORD_WIDTH),
            .IDX_W      (IDX_W),
            .CELL_INDEX (i)
        ) u_cell (
            .aclk      (aclk),
            .cmd       (cmd_gated),
            .sel_idx   (sel_idx),
            .wr_word   (wr_word),
            .prev_word (prev_w),
            .next_word (next_w),
            .word      (cell_word[i]),
            .rd_word   (cell_rd[i])
        );
    end

    // read bus: only the selected cell drives nonzero
    always_comb begin
        rd_any = '0;
        for (int k = 0; k < DEPTH; k++) begin
            rd_any = rd_any | cell_rd[k];
        end
    end

    assign read_value = VALUE_W'(rd_any[KEEP_W-1:0]);

    // result register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (accept) begin
            m_valid_next = 1'b1;
            m_data_next  = {{M_PAD_W{1'b0}}, status, COUNT_W'(count_next), read_value};
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            count_reg   <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (accept) begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

>>> src/pia_cell.sv
// ----------------------------------------------------------------------------
// pia_cell: one storage cell of the array chain
// Holds one word, loads it, or takes a neighbor's word on a shift.
// ----------------------------------------------------------------------------
module pia_cell
    import pia_pkg::*;
#(
    parameter int WORD_WIDTH = 32,
    parameter int IDX_W      = 4,
    parameter int CELL_INDEX = 0
) (
    input  logic                  aclk,
    input  pia_cmd_t              cmd,
    input  logic [IDX_W-1:0]      sel_idx,
    input  logic [WORD_WIDTH-1:0] wr_word,
    input  logic [WORD_WIDTH-1:0] prev_word,
    input  logic [WORD_WIDTH-1:0] next_word,
    output logic [WORD_WIDTH-1:0] word,
    output logic [WORD_WIDTH-1:0] rd_word
);

    logic [WORD_WIDTH-1:0] word_reg;
    logic [WORD_WIDTH-1:0] word_next;
    logic                  hit;
    logic                  above;

    // position of this cell against the selected index
    assign hit   = (sel_idx == IDX_W'(CELL_INDEX));
    assign above = (sel_idx < IDX_W'(CELL_INDEX));

    // next word: load, shift up, shift down or hold
    always_comb begin
        priority if (cmd.write && hit) begin
            word_next = wr_word;
        end else if (cmd.shift_up && above) begin
            word_next = prev_word;
        end else if (cmd.shift_down && (hit || above)) begin
            word_next = next_word;
        end else begin
            word_next = word_reg;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign word    = word_reg;
    assign rd_word = (cmd.read && hit) ? word_reg : '0;

endmodule

>>> src/pia_checker.sv
// ----------------------------------------------------------------------------
// pia_checker: port-level checks for the positional insert/erase array
// Watches the result channel for consistency of count, status and data.
// ----------------------------------------------------------------------------
module pia_checker
    import pia_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    logic [VALUE_W-1:0]  rd_f;
    logic [COUNT_W-1:0]  count_f;
    pia_status_e         status_f;

    assign rd_f     = m_tdata[RD_LSB +: VALUE_W];
    assign count_f  = m_tdata[COUNT_LSB +: COUNT_W];
    assign status_f = pia_status_e'(m_tdata[STATUS_LSB +: STATUS_W]);

    // stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed under stall");

    // full is reported only at capacity
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && status_f == ST_FULL |-> count_f == COUNT_W'(DEPTH))
        else $error("full status below capacity");

    // empty is reported only with no entries
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && status_f == ST_EMPTY |-> count_f == '0)
        else $error("empty status with entries in use");

    // a nonzero word comes only with an ok status
    a_rd_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && rd_f != '0 |-> status_f == ST_OK)
        else $error("read data on failed operation");

    // count stays within capacity
    a_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (DEPTH > 31) || (count_f <= COUNT_W'(DEPTH)))
        else $error("count beyond capacity");

endmodule

bind positional_insert_erase_array pia_checker #(
    .DEPTH (DEPTH)
) u_pia_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
